/* src/softmax_with_argmax_core_assert.svh */
// Assertion macros for the softmax with argmax core.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef SOFTMAX_WITH_ARGMAX_CORE_ASSERT_SVH
`define SOFTMAX_WITH_ARGMAX_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMAX_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("softmax core assertion failed");

// Next-cycle implication, checked out of reset.
`define SMAX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("softmax core assertion failed");

`endif

/* src/smax_pkg.sv */
// Package for the softmax with argmax core: sizes, state type and exp table.
// Depends on nothing.
`timescale 1ns / 1ps
package smax_pkg;

  localparam int MaxClasses   = 16;
  localparam int ExpTableBits = 10;
  localparam int ExpTableSize = 1 << ExpTableBits;
  localparam int IdxW         = $clog2(MaxClasses);
  localparam int CntW         = $clog2(MaxClasses + 2);
  localparam int TotalW       = 20;
  localparam int QuoW         = 17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_RD,
    ST_EXP_LK,
    ST_EXP_WR,
    ST_DIV_RD,
    ST_DIV_INIT,
    ST_DIV_RUN,
    ST_EMIT
  } state_e;

  typedef logic [15:0] exp_tab_t [ExpTableSize];

  // Shift and subtract quotient, used only while the table is built.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-x) for x = i/64 over 0..16, Q0.16, built with integer arithmetic only.
  function automatic exp_tab_t build_exp_table();
    exp_tab_t tab;
    longint unsigned f, t, pos, neg, v, r;
    for (int i = 0; i < ExpTableSize; i++) begin
      f   = longint'(i) << (30 - ExpTableBits);
      t   = 64'd1 << 30;
      pos = 64'd1 << 30;
      neg = 0;
      for (int k = 1; k <= 24; k++) begin
        t = udiv64((t * f) >> 30, 64'(k));
        if (k[0]) neg += t;
        else pos += t;
      end
      v = (pos > neg) ? pos - neg : 0;
      if (v > (64'd1 << 30)) v = 64'd1 << 30;
      for (int k = 0; k < 4; k++) v = (v * v + (64'd1 << 29)) >> 30;
      r = (v + (64'd1 << 13)) >> 14;
      if (r > 64'd65535) r = 64'd65535;
      tab[i] = r[15:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t ExpTable = build_exp_table();

endpackage

/* src/softmax_with_argmax_core.sv */
// Softmax with argmax over a vector of Q8.8 logits, one memory for logits and exps.
// Depends on smax_pkg and softmax_with_argmax_core_assert.svh.
`timescale 1ns / 1ps
// Logits load one per cycle while busy_o is low; the beat with last_logit_i set
// starts the run if the count matches, and busy_o stays high until the cycle that
// carries the last result. For each class the exp pass does a memory read, a table
// read and a write back; the divide and emit pass does a read, a setup, the
// one-bit-per-cycle divider (17 steps) and an emit. Results are
// one-cycle strobes on result_valid_o and cannot be held off. A count mismatch
// gives one result with status_o set.
module softmax_with_argmax_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic signed [15:0]        logit_i,
  input  logic                      last_logit_i,
  input  logic                      cfg_we_i,
  input  logic [4:0]                cfg_data_i,
  output logic                      result_valid_o,
  output logic [3:0]                class_index_o,
  output logic [15:0]               probability_o,
  output logic [3:0]                top_index_o,
  output logic [15:0]               best_prob_o,
  output logic                      status_o,
  output logic                      last_result_o
);
  import smax_pkg::*;

  state_e state_q, state_d;

  logic [4:0]              num_labels_q;
  logic [CntW-1:0]         count_q;
  logic signed [15:0]      max_q;
  logic [IdxW-1:0]         idx_q;
  logic [TotalW-1:0]       total_q;
  logic [15:0]             rd_q;
  logic [15:0]             rom_q;
  logic                    big_q;
  logic [TotalW-1:0]       rem_q;
  logic [QuoW-1:0]         nb_q;
  logic [QuoW-1:0]         quo_q;
  logic [4:0]              step_q;
  logic [IdxW-1:0]         best_idx_q;
  logic [15:0]             best_p_q;

  logic [15:0]             mem [MaxClasses];

  logic                    accept;
  logic [CntW-1:0]         count_nxt;
  logic                    mismatch;
  logic                    idx_last;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [15:0]             mem_wdata;
  logic [16:0]             m_diff;
  logic [25:0]             rom_idx_wide;
  logic [ExpTableBits-1:0] rom_addr;
  logic [15:0]             e_val;
  logic [32:0]             num;
  logic [TotalW:0]         r2;
  logic                    ge;
  logic [15:0]             p_sat;
  logic                    take_best;

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != ST_IDLE);
  assign idx_last = ({1'b0, idx_q} == count_q - CntW'(1));

  // Count after this beat; overflow parks at MaxClasses + 1.
  always_comb begin
    if (count_q < CntW'(MaxClasses)) count_nxt = count_q + CntW'(1);
    else count_nxt = CntW'(MaxClasses + 1);
  end
  assign mismatch = (count_nxt > CntW'(MaxClasses)) ||
                    (count_nxt != CntW'(num_labels_q));

  // Exp table address from the distance to the maximum.
  assign m_diff       = 17'(max_q) - 17'(signed'(rd_q));
  assign rom_idx_wide = (26'(m_diff[11:0]) << ExpTableBits) >> 12;
  assign rom_addr     = rom_idx_wide[ExpTableBits-1:0];
  assign e_val        = big_q ? 16'd0 : rom_q;

  // Divider numerator and one restoring step.
  assign num   = {1'b0, rd_q, 16'd0} + 33'(total_q >> 1);
  assign r2    = {rem_q, nb_q[QuoW-1]};
  assign ge    = (r2 >= {1'b0, total_q});
  assign p_sat = quo_q[QuoW-1] ? 16'hFFFF : quo_q[15:0];
  assign take_best = (idx_q == '0) || (p_sat > best_p_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && last_logit_i && !mismatch) state_d = ST_EXP_RD;
      end
      ST_EXP_RD:   state_d = ST_EXP_LK;
      ST_EXP_LK:   state_d = ST_EXP_WR;
      ST_EXP_WR:   state_d = idx_last ? ST_DIV_RD : ST_EXP_RD;
      ST_DIV_RD:   state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (step_q == 5'(QuoW - 1)) state_d = ST_EMIT;
      end
      ST_EMIT:     state_d = idx_last ? ST_IDLE : ST_DIV_RD;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Memory write port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = e_val;
    unique case (state_q)
      ST_IDLE: begin
        mem_we    = accept && (count_q < CntW'(MaxClasses));
        mem_waddr = count_q[IdxW-1:0];
        mem_wdata = logit_i;
      end
      ST_EXP_WR: mem_we = 1'b1;
      default:   mem_we = 1'b0;
    endcase
  end

  // Logit and exp memory, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q  <= mem[idx_q];
    rom_q <= ExpTable[rom_addr];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      num_labels_q   <= 5'd7;
      count_q        <= '0;
      max_q          <= 16'sh8000;
      idx_q          <= '0;
      total_q        <= '0;
      step_q         <= '0;
      best_idx_q     <= '0;
      best_p_q       <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= (state_q == ST_EMIT) || (accept && last_logit_i && mismatch);
      if (cfg_we_i) num_labels_q <= cfg_data_i;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (last_logit_i && mismatch) begin
              count_q <= '0;
              max_q   <= 16'sh8000;
            end else begin
              count_q <= count_nxt;
              if ((count_q < CntW'(MaxClasses)) && (logit_i > max_q)) max_q <= logit_i;
            end
            if (last_logit_i) begin
              idx_q   <= '0;
              total_q <= '0;
            end
          end
        end
        ST_EXP_WR: begin
          total_q <= total_q + TotalW'(e_val);
          idx_q   <= idx_last ? '0 : idx_q + IdxW'(1);
        end
        ST_DIV_INIT: step_q <= '0;
        ST_DIV_RUN:  step_q <= step_q + 5'd1;
        ST_EMIT: begin
          if (take_best) begin
            best_idx_q <= idx_q;
            best_p_q   <= p_sat;
          end
          if (idx_last) begin
            idx_q   <= '0;
            count_q <= '0;
            max_q   <= 16'sh8000;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers: exp flag, divider and result fields.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        class_index_o <= '0;
        probability_o <= '0;
        top_index_o   <= '0;
        best_prob_o   <= '0;
        status_o      <= 1'b1;
        last_result_o <= 1'b1;
      end
      ST_EXP_LK: big_q <= (m_diff >= 17'd4096);
      ST_DIV_INIT: begin
        rem_q <= TotalW'(num[32:QuoW]);
        nb_q  <= num[QuoW-1:0];
        quo_q <= '0;
      end
      ST_DIV_RUN: begin
        rem_q <= ge ? TotalW'(r2 - {1'b0, total_q}) : TotalW'(r2);
        nb_q  <= nb_q << 1;
        quo_q <= {quo_q[QuoW-2:0], ge};
      end
      ST_EMIT: begin
        class_index_o <= idx_q;
        probability_o <= p_sat;
        top_index_o   <= take_best ? idx_q : best_idx_q;
        best_prob_o   <= take_best ? p_sat : best_p_q;
        status_o      <= 1'b0;
        last_result_o <= idx_last;
      end
      default: begin
      end
    endcase
  end

`include "softmax_with_argmax_core_assert.svh"

  // An error beat is always the only and last beat of its run.
  `SMAX_ASSERT_IMPL(a_err_is_last, result_valid_o && status_o, last_result_o)
  // An error beat carries no probability.
  `SMAX_ASSERT_IMPL(a_err_zero, result_valid_o && status_o, probability_o == 16'd0)
  // While more beats of a run are due, the block stays busy.
  `SMAX_ASSERT_NEXT(a_more_busy, result_valid_o && !last_result_o, busy_o)

endmodule
